FILE: hdl/bfr_pkg.sv
package bfr_pkg;

   // Screen and store geometry.
   localparam int SCREEN_WIDTH  = 480;
   localparam int SCREEN_HEIGHT = 320;
   localparam int MAX_GLYPHS    = 256;
   localparam int MAX_HEIGHT    = 32;
   localparam int STORE_WORDS   = 8192;

   localparam int GLYPH_W  = $clog2(MAX_GLYPHS);
   localparam int ADDR_W   = $clog2(STORE_WORDS);
   localparam int HEIGHT_W = 6;
   localparam int BASE_W   = 14;
   localparam int STEP_W   = 3;

   // Input word kinds.
   localparam logic [1:0] KIND_LOAD_ROW   = 2'd0;
   localparam logic [1:0] KIND_LOAD_WIDTH = 2'd1;
   localparam logic [1:0] KIND_HOME       = 2'd2;
   localparam logic [1:0] KIND_DRAW       = 2'd3;

   // Control characters.
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_RETURN  = 8'd13;

   // Register indexes.
   localparam logic [2:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [2:0] CSR_INK_COLOR    = 3'd2;
   localparam logic [2:0] CSR_FIRST_CODE   = 3'd3;
   localparam logic [2:0] CSR_CODE_COUNT   = 3'd4;
   localparam logic [2:0] CSR_DEFAULT_CODE = 3'd5;
   localparam logic [2:0] CSR_GLYPH_HEIGHT = 3'd6;

   // Program step addresses.
   localparam logic [STEP_W-1:0] STEP_WAIT     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SUBST    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_LOOKUP   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_ROWS     = 3'd4;
   localparam logic [STEP_W-1:0] STEP_DRAIN    = 3'd5;
   localparam logic [STEP_W-1:0] STEP_ADVANCE  = 3'd6;

   // Datapath action of one control word.
   typedef enum logic [2:0] {
      ACT_WAIT,
      ACT_EXEC,
      ACT_SUBST,
      ACT_LOOKUP,
      ACT_ROWS,
      ACT_DRAIN,
      ACT_ADVANCE
   } act_type;

   // Jump condition of one control word.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_ACCEPT,
      COND_NOT_DRAW,
      COND_ROWS_LEFT,
      COND_PEND_BUSY
   } cond_type;

   typedef struct packed {
      act_type             act;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ucode_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic accept;
      logic draw;
      logic rows_left;
      logic pend_busy;
   } seq_status_type;

   // The control program.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type word;
      unique case (step)
         STEP_WAIT:     word = '{ACT_WAIT,    COND_NO_ACCEPT, STEP_WAIT};
         STEP_DISPATCH: word = '{ACT_EXEC,    COND_NOT_DRAW,  STEP_WAIT};
         STEP_SUBST:    word = '{ACT_SUBST,   COND_NEVER,     STEP_WAIT};
         STEP_LOOKUP:   word = '{ACT_LOOKUP,  COND_NEVER,     STEP_WAIT};
         STEP_ROWS:     word = '{ACT_ROWS,    COND_ROWS_LEFT, STEP_ROWS};
         STEP_DRAIN:    word = '{ACT_DRAIN,   COND_PEND_BUSY, STEP_DRAIN};
         STEP_ADVANCE:  word = '{ACT_ADVANCE, COND_ALWAYS,    STEP_WAIT};
         default:       word = '{ACT_WAIT,    COND_ALWAYS,    STEP_WAIT};
      endcase
      return word;
   endfunction

endpackage

FILE: hdl/bfr_seq.sv
module bfr_seq
   import bfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ucode_type      ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take;

   // Fetch the control word of the current step.
   assign ctrl = ucode_rom(step_ff);

   // Evaluate the jump condition.
   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:     take = 1'b0;
         COND_ALWAYS:    take = 1'b1;
         COND_NO_ACCEPT: take = !status.accept;
         COND_NOT_DRAW:  take = !status.draw;
         COND_ROWS_LEFT: take = status.rows_left;
         COND_PEND_BUSY: take = status.pend_busy;
         default:        take = 1'b1;
      endcase
      step_in = take ? ctrl.target : step_ff + 1'b1;
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: hdl/bitmap_font_text_renderer_top.sv
// A draw word goes through the dispatch, substitution, lookup, row, drain and advance steps;
// loads, home, newline and carriage return words return to waiting after dispatch.
// A draw word gives glyph_height (at most 32) rows, each from one glyph store read;
// a row is read only when the pending row can move on to the result register.
// Synchronous active-high reset clears the sequencer, the result register,
// the cursor and the registers to their defaults; glyph and width stores are not cleared.
module bitmap_font_text_renderer_top
   import bfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [12:0]        req_store_address,
   input  logic [15:0]        req_load_data,
   input  logic [7:0]         req_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_row_y,
   output logic signed [15:0] rsp_left_x,
   output logic [15:0]        rsp_pixel_mask,
   output logic [15:0]        rsp_pixel_color,
   output logic               rsp_last,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   // Saturate a sum that can only overflow upward.
   function automatic logic [15:0] sat_up(input logic [17:0] v);
      return (!v[17] && (v[16:15] != 2'b00)) ? 16'h7FFF : v[15:0];
   endfunction

   // Columns of the 16-pixel span that lie on screen.
   function automatic logic [15:0] col_mask(input logic [15:0] cx);
      logic [15:0] m;
      logic [16:0] px;
      for (int col = 0; col < 16; col++) begin
         px = {cx[15], cx} + 17'(col);
         m[15 - col] = !px[16] && (px < 17'(SCREEN_WIDTH));
      end
      return m;
   endfunction

   // Configuration registers.
   logic [15:0] origin_x_ff, origin_y_ff, ink_color_ff;
   logic [7:0]  first_code_ff, default_code_ff;
   logic [8:0]  code_count_ff;
   logic [5:0]  glyph_height_ff;

   // Latched input word.
   logic [1:0]  kind_ff;
   logic [12:0] addr_ff;
   logic [15:0] data_ff;
   logic [7:0]  code_ff;

   // Cursor.
   logic [15:0] cursor_x_ff, cursor_y_ff;

   // Per-character working registers.
   logic [7:0]          gi_ff;
   logic                gi_valid_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [15:0]         colmask_ff;
   logic [HEIGHT_W-1:0] row_ff;

   // Stores and their read registers.
   logic [15:0] glyph_mem [STORE_WORDS];
   logic [4:0]  width_mem [MAX_GLYPHS];
   logic [15:0] rd_word_ff;
   logic [4:0]  width_rd_ff;

   // Row waiting between the store read and the result register.
   logic                pend_ff;
   logic                pend_zero_ff;
   logic                pend_last_ff;
   logic [HEIGHT_W-1:0] pend_row_ff;

   // Result register.
   logic        rsp_valid_ff, rsp_last_ff;
   logic [15:0] rsp_row_y_ff, rsp_left_x_ff, rsp_mask_ff, rsp_color_ff;

   ucode_type      ctrl;
   seq_status_type status;

   logic                accept, draw, rows_left, issue, move, in_range, in_rows;
   logic [HEIGHT_W-1:0] h_eff;
   logic [7:0]          sub_code;
   logic [BASE_W-1:0]   row_addr;
   logic [4:0]          w_eff;
   logic [15:0]         wmask, mask_in;
   logic [17:0]         ry;

   bfr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Handshake and sequencer status.
   assign req_ready = (ctrl.act == ACT_WAIT) && !reset;
   assign accept    = req_valid && req_ready;
   assign draw      = (kind_ff == KIND_DRAW) && (code_ff != CODE_NEWLINE) &&
                      (code_ff != CODE_RETURN);
   assign h_eff     = (glyph_height_ff > HEIGHT_W'(MAX_HEIGHT)) ?
                      HEIGHT_W'(MAX_HEIGHT) : glyph_height_ff;
   assign rows_left = (row_ff < h_eff);
   assign status    = '{accept: accept, draw: draw, rows_left: rows_left,
                        pend_busy: pend_ff};

   // Code substitution for codes outside the font.
   assign in_range = (code_ff >= first_code_ff) &&
                     ({2'b00, code_ff} < ({2'b00, first_code_ff} + {1'b0, code_count_ff}));
   assign sub_code = in_range ? code_ff : default_code_ff;

   // Row issue and transfer into the result register.
   assign move     = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign issue    = (ctrl.act == ACT_ROWS) && rows_left && (!pend_ff || move);
   assign row_addr = base_ff + BASE_W'(row_ff);

   // Mask of one pending row, clipped to the glyph width and the screen.
   assign w_eff = gi_valid_ff ? width_rd_ff : 5'd0;
   assign wmask = ~(16'hFFFF >> w_eff);
   assign ry    = {{2{cursor_y_ff[15]}}, cursor_y_ff} + 18'(pend_row_ff);
   assign in_rows = !ry[17] && (ry < 18'(SCREEN_HEIGHT));
   always_comb begin
      mask_in = pend_zero_ff ? 16'h0000 : (rd_word_ff & wmask);
      mask_in = in_rows ? (mask_in & colmask_ff) : 16'h0000;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= 16'h0000;
         origin_y_ff     <= 16'h0000;
         ink_color_ff    <= 16'hFFFF;
         first_code_ff   <= 8'd32;
         code_count_ff   <= 9'd95;
         default_code_ff <= 8'd63;
         glyph_height_ff <= 6'd16;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X:     origin_x_ff     <= csr_write_data;
            CSR_ORIGIN_Y:     origin_y_ff     <= csr_write_data;
            CSR_INK_COLOR:    ink_color_ff    <= csr_write_data;
            CSR_FIRST_CODE:   first_code_ff   <= csr_write_data[7:0];
            CSR_CODE_COUNT:   code_count_ff   <= csr_write_data[8:0];
            CSR_DEFAULT_CODE: default_code_ff <= csr_write_data[7:0];
            CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   // Input word capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         addr_ff <= req_store_address;
         data_ff <= req_load_data;
         code_ff <= req_code;
      end
   end

   // Glyph store: written by row loads, read once per glyph row.
   always_ff @(posedge clock) begin
      if ((ctrl.act == ACT_EXEC) && (kind_ff == KIND_LOAD_ROW)) begin
         glyph_mem[addr_ff[ADDR_W-1:0]] <= data_ff;
      end
      if (issue) begin
         rd_word_ff <= glyph_mem[row_addr[ADDR_W-1:0]];
      end
   end

   // Width table: clamped on load, read once per character.
   always_ff @(posedge clock) begin
      if ((ctrl.act == ACT_EXEC) && (kind_ff == KIND_LOAD_WIDTH) &&
          (addr_ff < 13'(MAX_GLYPHS))) begin
         width_mem[addr_ff[GLYPH_W-1:0]] <= (data_ff > 16'd16) ? 5'd16 : data_ff[4:0];
      end
      if (ctrl.act == ACT_LOOKUP) begin
         width_rd_ff <= width_mem[gi_ff[GLYPH_W-1:0]];
      end
   end

   // Per-character setup and row counter.
   always_ff @(posedge clock) begin
      if (ctrl.act == ACT_SUBST) begin
         gi_ff <= sub_code - first_code_ff;
      end
      if (ctrl.act == ACT_LOOKUP) begin
         gi_valid_ff <= ({1'b0, gi_ff} < 9'(MAX_GLYPHS));
         base_ff     <= BASE_W'(gi_ff) * BASE_W'(h_eff);
         colmask_ff  <= col_mask(cursor_x_ff);
         row_ff      <= '0;
      end else if (issue) begin
         row_ff      <= row_ff + 1'b1;
      end
   end

   // Cursor moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= 16'h0000;
         cursor_y_ff <= 16'h0000;
      end else if ((ctrl.act == ACT_EXEC) && (kind_ff == KIND_HOME)) begin
         cursor_x_ff <= origin_x_ff;
         cursor_y_ff <= origin_y_ff;
      end else if ((ctrl.act == ACT_EXEC) && (kind_ff == KIND_DRAW) &&
                   (code_ff == CODE_NEWLINE)) begin
         cursor_x_ff <= origin_x_ff;
         cursor_y_ff <= sat_up({{2{cursor_y_ff[15]}}, cursor_y_ff} + 18'(h_eff) + 18'd2);
      end else if ((ctrl.act == ACT_EXEC) && (kind_ff == KIND_DRAW) &&
                   (code_ff == CODE_RETURN)) begin
         cursor_x_ff <= origin_x_ff;
      end else if (ctrl.act == ACT_ADVANCE) begin
         cursor_x_ff <= sat_up({{2{cursor_x_ff[15]}}, cursor_x_ff} + 18'(w_eff) + 18'd1);
      end
   end

   // Pending row tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (issue) begin
         pend_ff <= 1'b1;
      end else if (move) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         pend_row_ff  <= row_ff;
         pend_last_ff <= ({1'b0, row_ff} + 1'b1) == {1'b0, h_eff};
         pend_zero_ff <= !gi_valid_ff || (row_addr >= BASE_W'(STORE_WORDS));
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_row_y_ff  <= sat_up(ry);
         rsp_left_x_ff <= cursor_x_ff;
         rsp_mask_ff   <= mask_in;
         rsp_color_ff  <= ink_color_ff;
         rsp_last_ff   <= pend_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_y       = rsp_row_y_ff;
   assign rsp_left_x      = rsp_left_x_ff;
   assign rsp_pixel_mask  = rsp_mask_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A pending row exists only while rows are issued or drained.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (ctrl.act == ACT_ROWS || ctrl.act == ACT_DRAIN))
      else $error("pending row outside the row steps");

   // The cursor advance never happens with a row still pending.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == ACT_ADVANCE) |-> !pend_ff)
      else $error("cursor advance with a row still pending");

   // The cursor holds while rows of a character are produced.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == ACT_ROWS) |=> $stable(cursor_x_ff) && $stable(cursor_y_ff))
      else $error("cursor moved during row output");

   // No row is issued beyond the glyph height.
   assert property (@(posedge clock) disable iff (reset)
      issue |-> (row_ff < h_eff))
      else $error("row issued past the glyph height");
`endif

endmodule

FILE: test/tb_top.sv
module tb_top;
   import bfr_pkg::*;

   localparam int WATCHDOG_CYCLES = 4000;
   localparam int QUIET_CYCLES    = 16;

   // One expected framebuffer row write.
   typedef struct packed {
      logic [15:0] row_y;
      logic [15:0] left_x;
      logic [15:0] mask;
      logic [15:0] color;
      logic        last;
   } glyph_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = KIND_LOAD_ROW;
   logic [12:0]        req_store_address = '0;
   logic [15:0]        req_load_data = '0;
   logic [7:0]         req_code = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_row_y;
   logic signed [15:0] rsp_left_x;
   logic [15:0]        rsp_pixel_mask;
   logic [15:0]        rsp_pixel_color;
   logic               rsp_last;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index = CSR_ORIGIN_X;
   logic [15:0]        csr_write_data = '0;

   // Shadow copy of the renderer: stores, cursor and registers.
   logic [15:0] glyph_mem [STORE_WORDS];
   bit          glyph_mem_set [STORE_WORDS];
   logic [4:0]  width_mem [MAX_GLYPHS];
   bit          width_mem_set [MAX_GLYPHS];
   int          cur_x = 0;
   int          cur_y = 0;
   logic [15:0] cfg_org_x = '0;
   logic [15:0] cfg_org_y = '0;
   logic [15:0] cfg_ink = 16'hFFFF;
   logic [7:0]  cfg_first_code = 8'd32;
   logic [8:0]  cfg_code_count = 9'd95;
   logic [7:0]  cfg_dflt_code = 8'd63;
   logic [5:0]  cfg_glyph_h = 6'd16;

   glyph_row_type rows_due [$];
   glyph_row_type want_row;
   int          errors = 0;
   int          words_sent = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          quiet_cycles = 0;

   bitmap_font_text_renderer_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int sat16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Heights above the store limit are treated as the limit.
   function automatic int rows_per_glyph();
      return (cfg_glyph_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_glyph_h);
   endfunction

   // Glyph slot that a printable code resolves to, after default substitution.
   function automatic logic [7:0] glyph_index(input logic [7:0] code);
      logic [7:0] sel;
      sel = code;
      if (code < cfg_first_code || int'(code) >= int'(cfg_first_code) + int'(cfg_code_count))
         sel = cfg_dflt_code;
      return sel - cfg_first_code;
   endfunction

   // Updates the shadow state for one accepted word and queues its row writes.
   function automatic void apply_word(input logic [1:0] kind, input logic [12:0] addr,
                                      input logic [15:0] data, input logic [7:0] code);
      int            h, w, row, col, ry, px, a;
      logic [7:0]    gi;
      logic [15:0]   wmask, mask;
      glyph_row_type r;
      h = rows_per_glyph();
      case (kind)
         KIND_LOAD_ROW: begin
            glyph_mem[addr] = data;
            glyph_mem_set[addr] = 1'b1;
         end
         KIND_LOAD_WIDTH: begin
            // Indexes past the width table are dropped, and wide values clamp.
            if (addr < MAX_GLYPHS) begin
               width_mem[addr] = (data > 16) ? 5'd16 : data[4:0];
               width_mem_set[addr] = 1'b1;
            end
         end
         KIND_HOME: begin
            cur_x = int'($signed(cfg_org_x));
            cur_y = int'($signed(cfg_org_y));
         end
         KIND_DRAW: begin
            if (code == CODE_NEWLINE) begin
               cur_x = int'($signed(cfg_org_x));
               cur_y = sat16(cur_y + h + 2);
            end else if (code == CODE_RETURN) begin
               cur_x = int'($signed(cfg_org_x));
            end else begin
               gi = glyph_index(code);
               w = width_mem[gi];
               wmask = 16'(32'hFFFF << (16 - w));
               for (row = 0; row < h; row++) begin
                  a = int'(gi) * h + row;
                  mask = ((a < STORE_WORDS) ? glyph_mem[a] : 16'h0000) & wmask;
                  ry = cur_y + row;
                  // Clip against the screen edges.
                  if (ry < 0 || ry >= SCREEN_HEIGHT) begin
                     mask = '0;
                  end else begin
                     for (col = 0; col < 16; col++) begin
                        px = cur_x + col;
                        if (px < 0 || px >= SCREEN_WIDTH) mask[15 - col] = 1'b0;
                     end
                  end
                  r.row_y = 16'(sat16(ry));
                  r.left_x = 16'(cur_x);
                  r.mask = mask;
                  r.color = cfg_ink;
                  r.last = (row == h - 1);
                  rows_due.push_back(r);
               end
               cur_x = sat16(cur_x + w + 1);
            end
         end
         default: ;
      endcase
   endfunction

   // Offers one word, with random idle cycles first, and waits for acceptance.
   task automatic put_word(input logic [1:0] kind, input logic [12:0] addr,
                           input logic [15:0] data, input logic [7:0] code);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_store_address <= addr;
      req_load_data <= data;
      req_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_word(kind, addr, data, code);
      words_sent++;
   endtask

   // Width values: mostly legal, some just past the clamp, some fully random.
   function automatic logic [15:0] pick_width();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(17, 31));
         default: return 16'($urandom_range(0, 16));
      endcase
   endfunction

   // Sends a character, first loading any glyph row or width it would read unwritten.
   task automatic send_char(input logic [7:0] code);
      logic [7:0] gi;
      int         h, row, a;
      if (code != CODE_NEWLINE && code != CODE_RETURN) begin
         gi = glyph_index(code);
         h = rows_per_glyph();
         if (!width_mem_set[gi])
            put_word(KIND_LOAD_WIDTH, 13'(gi), pick_width(), 8'($urandom));
         for (row = 0; row < h; row++) begin
            a = int'(gi) * h + row;
            if (a < STORE_WORDS && !glyph_mem_set[a])
               put_word(KIND_LOAD_ROW, 13'(a), 16'($urandom), 8'($urandom));
         end
      end
      put_word(KIND_DRAW, 13'($urandom), 16'($urandom), code);
   endtask

   // Holds the sender off until every row write has arrived and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      case (index)
         CSR_ORIGIN_X:     cfg_org_x = value;
         CSR_ORIGIN_Y:     cfg_org_y = value;
         CSR_INK_COLOR:    cfg_ink = value;
         CSR_FIRST_CODE:   cfg_first_code = value[7:0];
         CSR_CODE_COUNT:   cfg_code_count = value[8:0];
         CSR_DEFAULT_CODE: cfg_dflt_code = value[7:0];
         CSR_GLYPH_HEIGHT: cfg_glyph_h = value[5:0];
         default: ;
      endcase
   endtask

   // Rewrites every register once the block has gone idle.
   task automatic program_font(input logic [15:0] ox, input logic [15:0] oy,
                               input logic [15:0] ink_v, input logic [7:0] first,
                               input logic [8:0] count, input logic [7:0] dflt,
                               input logic [5:0] height);
      settle();
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_INK_COLOR, ink_v);
      write_reg(CSR_FIRST_CODE, {8'h00, first});
      write_reg(CSR_CODE_COUNT, {7'h00, count});
      write_reg(CSR_DEFAULT_CODE, {8'h00, dflt});
      write_reg(CSR_GLYPH_HEIGHT, {10'h000, height});
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Origins are mostly on screen, with some near both ends of the range.
   function automatic logic [15:0] pick_origin(input int span);
      case ($urandom_range(0, 7))
         0: return 16'($urandom);
         1: return 16'(32767 - int'($urandom_range(0, 40)));
         2: return 16'(-32768 + int'($urandom_range(0, 40)));
         3: return 16'(-int'($urandom_range(0, 20)));
         default: return 16'($urandom_range(0, span));
      endcase
   endfunction

   task automatic random_font();
      logic [8:0] count;
      logic [5:0] height;
      case ($urandom_range(0, 5))
         0: count = 9'd0;
         1: count = 9'd256;
         default: count = 9'($urandom_range(1, 256));
      endcase
      case ($urandom_range(0, 7))
         0: height = 6'd0;
         1: height = 6'd32;
         2: height = 6'($urandom_range(33, 63));
         default: height = 6'($urandom_range(1, 16));
      endcase
      program_font(pick_origin(470), pick_origin(310), 16'($urandom), 8'($urandom), count,
                   8'($urandom), height);
      // Sometimes the cursor keeps its old position under the new origin.
      if ($urandom_range(0, 3) != 0)
         put_word(KIND_HOME, 13'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // Reset register values, store end words, control characters, default substitution.
   task automatic test_reset_defaults();
      put_word(KIND_LOAD_ROW, 13'd0, 16'h0000, 8'h00);
      put_word(KIND_LOAD_ROW, 13'h1FFF, 16'hFFFF, 8'hFF);
      put_word(KIND_HOME, 13'h0000, 16'h0000, 8'h00);
      send_char("H");
      send_char(CODE_RETURN);
      send_char(CODE_NEWLINE);
      send_char(8'd0);
      send_char(8'd255);
   endtask

   // Width loads above 16 clamp, and loads past the width table are dropped.
   task automatic test_width_clamp();
      put_word(KIND_LOAD_WIDTH, 13'(glyph_index("W")), 16'hFFFF, 8'h00);
      send_char("W");
      put_word(KIND_LOAD_WIDTH, 13'(glyph_index("W")), 16'd17, 8'h00);
      send_char("W");
      put_word(KIND_LOAD_WIDTH, 13'(glyph_index("W")), 16'd0, 8'h00);
      put_word(KIND_LOAD_WIDTH, 13'h1FFF, 16'd5, 8'h00);
      send_char("W");
   endtask

   // Full code range, defaults outside the range, tall heights and screen clipping.
   task automatic test_substitution_clipping();
      program_font(-16'sd8, -16'sd3, 16'h0000, 8'd0, 9'd256, 8'd255, 6'd32);
      put_word(KIND_HOME, 13'h1555, 16'hAAAA, 8'h55);
      send_char(8'd255);
      send_char(CODE_NEWLINE);
      send_char(8'd0);
      program_font(16'd470, 16'd315, 16'h07E0, 8'd200, 9'd0, 8'd100, 6'd40);
      put_word(KIND_HOME, 13'h0AAA, 16'h5555, 8'hAA);
      send_char("A");
   endtask

   // A zero height gives no rows but still moves the cursor.
   task automatic test_zero_height();
      program_font(16'd100, 16'd100, 16'hF800, 8'd32, 9'd95, 8'd63, 6'd0);
      put_word(KIND_HOME, 13'h0000, 16'h0000, 8'h00);
      send_char("a");
      program_font(16'd100, 16'd100, 16'hF800, 8'd32, 9'd95, 8'd63, 6'd1);
      send_char("d");
   endtask

   // Cursor and row positions saturate at the top of the signed range; the bottom end is also driven.
   task automatic test_saturation();
      program_font(16'd32760, 16'd32766, 16'h001F, 8'd32, 9'd95, 8'd63, 6'd4);
      put_word(KIND_LOAD_WIDTH, 13'(glyph_index("M")), 16'd16, 8'h00);
      put_word(KIND_HOME, 13'h0000, 16'h0000, 8'h00);
      send_char("M");
      send_char("M");
      send_char(CODE_NEWLINE);
      send_char("M");
      program_font(16'h8000, 16'h8000, 16'hFFFF, 8'd32, 9'd95, 8'd63, 6'd4);
      send_char("M");
      put_word(KIND_HOME, 13'h0000, 16'h0000, 8'h00);
      send_char("M");
      send_char(CODE_RETURN);
   endtask

   // Mostly text drawn from a small set of glyphs, mixed with loads and stray codes.
   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int count);
      int stop_at, refont_at, pick;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      random_font();
      stop_at = words_sent + count;
      refont_at = words_sent + int'($urandom_range(count / 4, 3 * count / 4));
      while (words_sent < stop_at) begin
         if (words_sent >= refont_at) begin
            random_font();
            refont_at = stop_at;
         end
         pick = $urandom_range(0, 99);
         if (pick < 58)
            send_char(cfg_first_code + 8'($urandom_range(0, 11)));
         else if (pick < 68)
            send_char(8'($urandom));
         else if (pick < 76)
            send_char(CODE_NEWLINE);
         else if (pick < 80)
            send_char(CODE_RETURN);
         else if (pick < 86)
            put_word(KIND_HOME, 13'($urandom), 16'($urandom), 8'($urandom));
         else if (pick < 93)
            put_word(KIND_LOAD_ROW, 13'($urandom), 16'($urandom), 8'($urandom));
         else
            put_word(KIND_LOAD_WIDTH,
                     ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 255)),
                     pick_width(), 8'($urandom));
      end
   endtask

   // Row write checker and random result-side stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rows_due.size() == 0) begin
            $error("unexpected row write: row_y %0d left_x %0d mask %h",
                   rsp_row_y, rsp_left_x, rsp_pixel_mask);
            errors++;
         end else begin
            want_row = rows_due.pop_front();
            if (rsp_row_y !== want_row.row_y) begin
               $error("row_y: expected %0d, got %0d", $signed(want_row.row_y), rsp_row_y);
               errors++;
            end
            if (rsp_left_x !== want_row.left_x) begin
               $error("left_x: expected %0d, got %0d", $signed(want_row.left_x), rsp_left_x);
               errors++;
            end
            if (rsp_pixel_mask !== want_row.mask) begin
               $error("pixel_mask: expected %h, got %h", want_row.mask, rsp_pixel_mask);
               errors++;
            end
            if (rsp_pixel_color !== want_row.color) begin
               $error("pixel_color: expected %h, got %h", want_row.color, rsp_pixel_color);
               errors++;
            end
            if (rsp_last !== want_row.last) begin
               $error("last: expected %0b, got %0b", want_row.last, rsp_last);
               errors++;
            end
         end
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Watchdog: ends the run after a long stretch with no word moving on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_width_clamp();
      test_substitution_clipping();
      test_zero_height();
      test_saturation();
      test_random_traffic(0, 0, 70);
      test_random_traffic(67, 0, 70);
      test_random_traffic(0, 67, 70);
      test_random_traffic(35, 35, 70);
      settle();
      if (errors == 0 && rows_due.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

FILE: sim.f
hdl/bfr_pkg.sv
hdl/bfr_seq.sv
hdl/bitmap_font_text_renderer_top.sv
test/tb_top.sv
